// ===== rtl/core/acfd_pkg.sv =====
// package for the adc channel average and fault debounce block
// types, widths, register indexes and reset values; no dependencies
package acfd_pkg;

    localparam int CHANNELS_DEF  = 2;
    localparam int AVG_SHIFT_DEF = 6;

    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 16;
    localparam int AVG_W    = 10;
    localparam int CNT_W    = 8;
    localparam int LIMIT_W  = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LIMIT      = 2'd0,
        CFG_HIGH_LIMIT     = 2'd1,
        CFG_DEBOUNCE_LIMIT = 2'd2
    } t_cfg_idx;

    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST      = 10'd5;
    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST     = 10'd1000;
    localparam logic [CNT_W-1:0]   DEBOUNCE_LIMIT_RST = 8'd100;

    // per-channel state held in the state memory
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [AVG_W-1:0] avg;
        logic [CNT_W-1:0] oor_cnt;
        logic [CNT_W-1:0] inr_cnt;
    } t_chan_entry;

    typedef struct packed {
        logic             channel;
        logic             avg_valid;
        logic [AVG_W-1:0] avg;
        logic             fault_declared;
        logic             fault_cleared;
        logic             averages_ready;
    } t_result;

endpackage

// ===== rtl/core/acfd_state_mem.sv =====
// per-channel state memory with registered read
// entry valid bits give zero before first write; write-to-read forwarding
// depends on acfd_pkg
module acfd_state_mem #(
    parameter int CHANNELS = acfd_pkg::CHANNELS_DEF,
    parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [CH_W-1:0]       i_rd_addr,
    output acfd_pkg::t_chan_entry o_rd_entry,
    input  logic                  i_wr_en,
    input  logic [CH_W-1:0]       i_wr_addr,
    input  acfd_pkg::t_chan_entry i_wr_entry
);
    import acfd_pkg::*;

    t_chan_entry         r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    t_chan_entry         r_rd_data;
    logic                r_rd_vld;
    logic                r_fwd;
    t_chan_entry         r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
                r_fwd    <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    // same-edge write to the entry being read wins over the stale read
    assign o_rd_entry = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);

endmodule

// ===== rtl/core/adc_channel_average_fault_debounce.sv =====
// adc channel averaging with range fault debounce, top level
// depends on acfd_pkg and acfd_state_mem
//
// One converter sample per input transaction, channels served round-robin
// from channel 0. Each sample gives exactly one output transaction: the
// channel, the channel average (new when average_valid is set, otherwise the
// last stored one), fault declared/cleared pulses and the averages-ready
// pulse with the result of the last channel of round zero. Throughput is one
// sample per clock while the sink takes results. The state memory read issued
// at acceptance is registered beside the sample in the update stage, the
// update is combinational, and the result and write-back land as that stage
// advances. A result held by the sink stalls the input once the update stage
// also holds a sample. State memory entries read as zero until first written,
// so the block takes samples straight out of reset. The user must write limit
// registers through the cfg port only while no transaction is in flight; the
// block itself does not enforce this.
module adc_channel_average_fault_debounce #(
    parameter int CHANNELS  = acfd_pkg::CHANNELS_DEF,
    parameter int AVG_SHIFT = acfd_pkg::AVG_SHIFT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [acfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [acfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [9:0] sample, [15:10] zero
    input  logic [acfd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] average_valid, [10:1] average, [11] fault_declared,
    // [12] fault_cleared, [13] averages_ready, [15:14] zero
    output logic [acfd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] channel
    output logic                             m_axis_tuser
);
    import acfd_pkg::*;

    localparam int               CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0]  LAST_CH = CH_W'(CHANNELS - 1);

    logic [LIMIT_W-1:0]  r_low_limit;
    logic [LIMIT_W-1:0]  r_high_limit;
    logic [CNT_W-1:0]    r_debounce_limit;

    logic [CH_W-1:0]      r_chan;
    logic [AVG_SHIFT-1:0] r_round;

    logic                r_s1_v;
    logic [CH_W-1:0]     r_s1_ch;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_s1_round_zero;
    logic                r_s1_ready;

    logic                r_out_v;
    t_result             r_out;

    logic                w_s_acc;
    logic                w_adv;
    t_chan_entry         w_entry;
    t_chan_entry         n_entry;
    t_result             n_res;
    logic [SUM_W-1:0]    w_sum;
    logic [SUM_W-1:0]    w_shifted;
    logic                w_oor;
    logic [CNT_W-1:0]    w_oor_inc;
    logic [CNT_W-1:0]    w_inr_inc;

    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_adv         = r_s1_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !r_s1_v || w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit      <= LOW_LIMIT_RST;
            r_high_limit     <= HIGH_LIMIT_RST;
            r_debounce_limit <= DEBOUNCE_LIMIT_RST;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOW_LIMIT:      r_low_limit      <= i_cfg_data[LIMIT_W-1:0];
                CFG_HIGH_LIMIT:     r_high_limit     <= i_cfg_data[LIMIT_W-1:0];
                CFG_DEBOUNCE_LIMIT: r_debounce_limit <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // channel sequencer and read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= '0;
            r_round <= '0;
            r_s1_v  <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_s1_v <= 1'b1;
                if (r_chan == LAST_CH) begin
                    r_chan  <= '0;
                    r_round <= r_round + 1'b1;
                end else begin
                    r_chan <= r_chan + 1'b1;
                end
            end else if (w_adv) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_s1_ch         <= r_chan;
            r_s1_sample     <= s_axis_tdata[SAMPLE_W-1:0];
            r_s1_round_zero <= (r_round == '0);
            r_s1_ready      <= (r_chan == LAST_CH) && (r_round == '0);
        end
    end

    acfd_state_mem #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_state_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_s_acc),
        .i_rd_addr  (r_chan),
        .o_rd_entry (w_entry),
        .i_wr_en    (w_adv),
        .i_wr_addr  (r_s1_ch),
        .i_wr_entry (n_entry)
    );

    // update stage
    always_comb begin
        w_sum     = w_entry.sum + SUM_W'(r_s1_sample);
        w_shifted = w_sum >> AVG_SHIFT;
        w_oor     = (r_s1_sample < r_low_limit) || (r_s1_sample > r_high_limit);
        w_oor_inc = w_entry.oor_cnt + 1'b1;
        w_inr_inc = w_entry.inr_cnt + 1'b1;
        n_entry   = w_entry;
        n_res     = '0;

        if (r_s1_round_zero) begin
            n_entry.avg = w_shifted[AVG_W-1:0];
            n_entry.sum = '0;
        end else begin
            n_entry.sum = w_sum;
        end

        if (w_oor) begin
            n_entry.inr_cnt = '0;
            if (w_oor_inc >= r_debounce_limit) begin
                n_entry.oor_cnt      = '0;
                n_res.fault_declared = 1'b1;
            end else begin
                n_entry.oor_cnt = w_oor_inc;
            end
        end else begin
            n_entry.oor_cnt = '0;
            if (w_inr_inc >= r_debounce_limit) begin
                n_entry.inr_cnt     = '0;
                n_res.fault_cleared = 1'b1;
            end else begin
                n_entry.inr_cnt = w_inr_inc;
            end
        end

        n_res.channel        = r_s1_ch[0];
        n_res.avg_valid      = r_s1_round_zero;
        n_res.avg            = n_entry.avg;
        n_res.averages_ready = r_s1_ready;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.channel;
    assign m_axis_tdata  = {2'b00, r_out.averages_ready, r_out.fault_cleared,
                            r_out.fault_declared, r_out.avg, r_out.avg_valid};

    a_ready_with_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.averages_ready |-> r_out.avg_valid)
        else $error("averages ready without a new average");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_out.fault_declared && r_out.fault_cleared))
        else $error("fault declared and cleared together");

    a_chan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && (r_chan != LAST_CH) |=> r_chan == $past(r_chan) + 1'b1)
        else $error("channel index did not advance");

    a_chan_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && (r_chan == LAST_CH) |=> r_chan == '0)
        else $error("channel index did not wrap");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !w_adv |=> r_s1_v && $stable(r_s1_ch) && $stable(r_s1_sample))
        else $error("update stage lost a stalled sample");

endmodule

// ===== sim/acfd_checker.sv =====
`timescale 1ns / 100ps
// checker for the adc channel average and fault debounce block: watches the
// sample, result and limit-register ports, predicts each result and compares
// depends on acfd_pkg only
module acfd_checker #(
    parameter int CHANNELS  = acfd_pkg::CHANNELS_DEF,
    parameter int AVG_SHIFT = acfd_pkg::AVG_SHIFT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [acfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [acfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [acfd_pkg::S_TDATA_W-1:0]  i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [acfd_pkg::M_TDATA_W-1:0]  i_out_data,
    input  logic                            i_out_user,
    output int                              o_pending,
    output int                              o_fail_count
);
    import acfd_pkg::*;

    logic [LIMIT_W-1:0]   low_lim;
    logic [LIMIT_W-1:0]   high_lim;
    logic [CNT_W-1:0]     deb_lim;
    int unsigned          chan;
    logic [AVG_SHIFT-1:0] round_cnt;
    logic [SUM_W-1:0]     sum_acc [CHANNELS];
    logic [AVG_W-1:0]     avg_hold [CHANNELS];
    logic [CNT_W-1:0]     oor_cnt [CHANNELS];
    logic [CNT_W-1:0]     inr_cnt [CHANNELS];
    t_result              due_reports [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function automatic t_result channel_step(input logic [SAMPLE_W-1:0] s);
        t_result r;
        r = '0;
        r.channel = chan[0];
        sum_acc[chan] = sum_acc[chan] + SUM_W'(s);
        if (round_cnt == '0) begin
            avg_hold[chan] = AVG_W'(sum_acc[chan] >> AVG_SHIFT);
            sum_acc[chan] = '0;
            r.avg_valid = 1'b1;
        end
        if (s < low_lim || s > high_lim) begin
            inr_cnt[chan] = '0;
            oor_cnt[chan] = oor_cnt[chan] + 1'b1;
            if (oor_cnt[chan] >= deb_lim) begin
                oor_cnt[chan] = '0;
                r.fault_declared = 1'b1;
            end
        end else begin
            oor_cnt[chan] = '0;
            inr_cnt[chan] = inr_cnt[chan] + 1'b1;
            if (inr_cnt[chan] >= deb_lim) begin
                inr_cnt[chan] = '0;
                r.fault_cleared = 1'b1;
            end
        end
        r.avg = avg_hold[chan];
        if (chan == CHANNELS - 1) begin
            chan = 0;
            if (round_cnt == '0)
                r.averages_ready = 1'b1;
            round_cnt = round_cnt + 1'b1;
        end else begin
            chan++;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            low_lim   = LOW_LIMIT_RST;
            high_lim  = HIGH_LIMIT_RST;
            deb_lim   = DEBOUNCE_LIMIT_RST;
            chan      = 0;
            round_cnt = '0;
            for (int k = 0; k < CHANNELS; k++) begin
                sum_acc[k]  = '0;
                avg_hold[k] = '0;
                oor_cnt[k]  = '0;
                inr_cnt[k]  = '0;
            end
            due_reports.delete();
        end else begin
            if (i_cfg_wen) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LOW_LIMIT:      low_lim = i_cfg_data[LIMIT_W-1:0];
                    CFG_HIGH_LIMIT:     high_lim = i_cfg_data[LIMIT_W-1:0];
                    CFG_DEBOUNCE_LIMIT: deb_lim = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                due_reports.push_back(channel_step(i_in_data[SAMPLE_W-1:0]));
            if (i_out_valid && i_out_ready) begin
                got.channel        = i_out_user;
                got.avg_valid      = i_out_data[0];
                got.avg            = i_out_data[AVG_W:1];
                got.fault_declared = i_out_data[AVG_W+1];
                got.fault_cleared  = i_out_data[AVG_W+2];
                got.averages_ready = i_out_data[AVG_W+3];
                if (due_reports.size() == 0) begin
                    report_mismatch("result with nothing due", 1, 0);
                end else begin
                    want = due_reports.pop_front();
                    if (got.channel !== want.channel)
                        report_mismatch("channel", got.channel, want.channel);
                    if (got.avg_valid !== want.avg_valid)
                        report_mismatch("average_valid", got.avg_valid, want.avg_valid);
                    if (got.avg !== want.avg)
                        report_mismatch("average", got.avg, want.avg);
                    if (got.fault_declared !== want.fault_declared)
                        report_mismatch("fault_declared", got.fault_declared,
                                        want.fault_declared);
                    if (got.fault_cleared !== want.fault_cleared)
                        report_mismatch("fault_cleared", got.fault_cleared,
                                        want.fault_cleared);
                    if (got.averages_ready !== want.averages_ready)
                        report_mismatch("averages_ready", got.averages_ready,
                                        want.averages_ready);
                end
            end
        end
        o_pending <= due_reports.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// testbench top for the adc channel average and fault debounce block: clock,
// reset, sample and limit stimulus, result back-pressure and the verdict
// depends on acfd_pkg, the block itself and acfd_checker
module tb;
    import acfd_pkg::*;

    localparam int RX_HOLD        = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 6;
    localparam int SEG_ITEMS      = 67;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [9:0] sample, [15:10] zero
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [0] average_valid, [10:1] average, [11] fault_declared,
    // [12] fault_cleared, [13] averages_ready, [15:14] zero
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // [0] channel
    logic                  m_axis_tuser;

    int pending;
    int fail_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int cur_low;
    int cur_high;

    adc_channel_average_fault_debounce i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    acfd_checker i_acfd_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side back-pressure, with a long hold-off on request
    initial begin
        int served;
        served = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (served != hold_requests) begin
                served = hold_requests;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_sample(input int s);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(s[SAMPLE_W-1:0]);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_results_done;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        if (idx == CFG_LOW_LIMIT)
            cur_low = val;
        else if (idx == CFG_HIGH_LIMIT)
            cur_high = val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick_sample(input bit out_of_range);
        if (!out_of_range && cur_low <= cur_high)
            return $urandom_range(cur_high, cur_low);
        if (cur_low > 0 && (cur_high == 1023 || $urandom_range(1) == 1))
            return $urandom_range(cur_low - 1, 0);
        if (cur_high < 1023)
            return $urandom_range(1023, cur_high + 1);
        return $urandom_range(1023);
    endfunction

    // runs of one kind per stretch so the debounce counters get to their limit
    task automatic random_samples(input int n_items);
        int done;
        int run_len;
        bit run_out;
        done = 0;
        while (done < n_items) begin
            run_len = $urandom_range(24, 1);
            run_out = $urandom_range(1);
            for (int k = 0; k < run_len && done < n_items; k++) begin
                if ($urandom_range(9) == 0)
                    send_sample($urandom_range(1023));
                else
                    send_sample(pick_sample(run_out));
                done++;
            end
        end
    endtask

    task automatic set_segment_limits(input int seg);
        case (seg % 4)
            0: begin
                write_reg(CFG_LOW_LIMIT, $urandom_range(100, 0));
                write_reg(CFG_HIGH_LIMIT, $urandom_range(1023, 900));
                write_reg(CFG_DEBOUNCE_LIMIT, $urandom_range(6, 1));
            end
            1: begin
                write_reg(CFG_LOW_LIMIT, 0);
                write_reg(CFG_HIGH_LIMIT, 1023);
                write_reg(CFG_DEBOUNCE_LIMIT, 1);
            end
            2: begin
                write_reg(CFG_LOW_LIMIT, $urandom_range(500, 300));
                write_reg(CFG_HIGH_LIMIT, $urandom_range(700, 500));
                write_reg(CFG_DEBOUNCE_LIMIT, 255);
            end
            default: begin
                write_reg(CFG_LOW_LIMIT, $urandom_range(1023));
                write_reg(CFG_HIGH_LIMIT, $urandom_range(1023));
                write_reg(CFG_DEBOUNCE_LIMIT, $urandom_range(12, 1));
            end
        endcase
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wen     = 1'b0;
        i_cfg_idx     = CFG_LOW_LIMIT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_requests = 0;
        tx_idle_pct   = 6;
        rx_idle_pct   = 71;
        cur_low       = LOW_LIMIT_RST;
        cur_high      = HIGH_LIMIT_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first round after reset, then the reset limits at their edges
        send_sample(1023);
        send_sample(0);
        send_sample(4);
        send_sample(5);
        send_sample(1000);
        send_sample(1001);

        wait_results_done();
        write_reg(CFG_DEBOUNCE_LIMIT, 1);
        send_sample(4);
        send_sample(1001);
        send_sample(5);
        send_sample(1000);

        // low limit above high limit
        wait_results_done();
        write_reg(CFG_LOW_LIMIT, 1023);
        write_reg(CFG_HIGH_LIMIT, 0);
        send_sample(512);
        send_sample(0);
        send_sample(1023);
        send_sample(700);

        wait_results_done();
        write_reg(CFG_DEBOUNCE_LIMIT, 0);
        send_sample(300);
        send_sample(300);

        // debounce limit dropped below a count already built up
        wait_results_done();
        write_reg(CFG_LOW_LIMIT, 0);
        write_reg(CFG_HIGH_LIMIT, 1023);
        write_reg(CFG_DEBOUNCE_LIMIT, 255);
        repeat (6) send_sample($urandom_range(1023));
        wait_results_done();
        write_reg(CFG_DEBOUNCE_LIMIT, 2);
        send_sample(341);
        send_sample(682);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_results_done();
            set_segment_limits(seg);
            case (seg / 2)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 71;
                end
                1: begin
                    tx_idle_pct = 71;
                    rx_idle_pct = 6;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (seg == 4) begin
                random_samples(20);
                hold_requests++;
                random_samples(SEG_ITEMS - 20);
            end else begin
                random_samples(SEG_ITEMS);
            end
        end

        wait_results_done();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
